// ===== src/sbda_pkg.sv =====
// Shared types and constants for the signed binary to decimal ASCII unit.
// No dependencies; every other file refers to it by scoped names.
package sbda_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 6;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int IDX_W      = 4;
   localparam int STEP_BITS  = 4;
   localparam int STEPS      = VALUE_W / STEP_BITS;
   localparam int STEP_CNT_W = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

   // One classified number: sign and BCD digits of the magnitude.
   typedef struct packed {
      logic             neg;
      logic [BCD_W-1:0] bcd;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/sbda_front.sv =====
// Front end: accepts a signed word, takes its magnitude and converts it to BCD
// by double dabble, four bits per cycle. Depends on sbda_pkg.
module sbda_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sbda_pkg::VALUE_W-1:0] req_value,
   input  sbda_pkg::queue_status_type          queue_status,
   output logic                                push,
   output sbda_pkg::entry_type                 push_data
);

   logic                            active_ff, active_in;
   logic                            done_ff, done_in;
   logic [sbda_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [sbda_pkg::VALUE_W-1:0]    bin_ff, bin_in;
   logic [sbda_pkg::BCD_W-1:0]      bcd_ff, bcd_in;
   logic                            neg_ff, neg_in;
   logic                            accept;
   logic [sbda_pkg::VALUE_W-1:0]    raw;
   logic [sbda_pkg::BCD_W-1:0]      bcd_step;

   // Four double-dabble bit steps on the BCD word, MSB of the nibble first.
   function automatic logic [sbda_pkg::BCD_W-1:0] dabble(
      input logic [sbda_pkg::BCD_W-1:0]     bcd,
      input logic [sbda_pkg::STEP_BITS-1:0] bits
   );
      logic [sbda_pkg::BCD_W-1:0] b;
      b = bcd;
      for (int s = sbda_pkg::STEP_BITS - 1; s >= 0; s--) begin
         for (int d = 0; d < sbda_pkg::NUM_DIGITS; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
               b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
         end
         b = {b[sbda_pkg::BCD_W-2:0], bits[s]};
      end
      return b;
   endfunction

   assign busy      = active_ff || (done_ff && queue_status.full);
   assign accept    = start && !busy;
   assign push      = done_ff && !queue_status.full;
   assign push_data = '{neg: neg_ff, bcd: bcd_ff};
   assign raw       = req_value;
   assign bcd_step  = dabble(bcd_ff,
                             bin_ff[sbda_pkg::VALUE_W-1 -: sbda_pkg::STEP_BITS]);

   always_comb begin
      active_in = active_ff;
      done_in   = done_ff;
      cnt_in    = cnt_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      neg_in    = neg_ff;
      if (push) begin
         done_in = 1'b0;
      end
      if (accept) begin
         neg_in    = raw[sbda_pkg::VALUE_W-1];
         bin_in    = raw[sbda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
         bcd_in    = '0;
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         bcd_in = bcd_step;
         bin_in = bin_ff << sbda_pkg::STEP_BITS;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sbda_pkg::STEP_CNT_W'(sbda_pkg::STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== src/sbda_queue.sv =====
// Short queue of converted numbers between front and back end.
// Depends on sbda_pkg.
module sbda_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sbda_pkg::entry_type        push_data,
   input  logic                       pop,
   output sbda_pkg::entry_type        head_data,
   output sbda_pkg::queue_status_type status
);

   sbda_pkg::entry_type              slot_ff [sbda_pkg::QUEUE_DEPTH];
   logic [sbda_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sbda_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sbda_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [sbda_pkg::QUEUE_PTR_W-1:0] advance(
      input logic [sbda_pkg::QUEUE_PTR_W-1:0] p
   );
      if (p == sbda_pkg::QUEUE_PTR_W'(sbda_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign status.full  = (count_ff == sbda_pkg::QUEUE_CNT_W'(sbda_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? advance(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/sbda_back.sv =====
// Back end: walks one queued number, emitting the sign and the digits with
// leading zeros dropped, one character per cycle. Depends on sbda_pkg.
module sbda_back (
   input  logic                              clock,
   input  logic                              reset,
   input  sbda_pkg::entry_type               head_data,
   input  sbda_pkg::queue_status_type        queue_status,
   output logic                              pop,
   output logic                              rsp_strobe,
   output logic [sbda_pkg::CHAR_W-1:0]       rsp_character,
   output logic                              rsp_last
);

   logic                            loaded_ff, loaded_in;
   logic                            sign_ff, sign_in;
   logic [sbda_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [sbda_pkg::BCD_W-1:0]      bcd_ff, bcd_in;
   logic                            strobe_ff, strobe_in;
   logic [sbda_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                            last_ff, last_in;
   logic                            finishing;
   logic [sbda_pkg::IDX_W-1:0]      msd;
   logic [3:0]                      digit;

   // Most significant nonzero digit of the head entry; zero gives index 0.
   always_comb begin
      msd = '0;
      for (int i = 0; i < sbda_pkg::NUM_DIGITS; i++) begin
         if (head_data.bcd[i*4 +: 4] != 4'd0) begin
            msd = sbda_pkg::IDX_W'(i);
         end
      end
   end

   assign digit     = bcd_ff[idx_ff*4 +: 4];
   assign finishing = loaded_ff && !sign_ff && (idx_ff == '0);
   assign pop       = !queue_status.empty && (!loaded_ff || finishing);

   always_comb begin
      loaded_in = loaded_ff;
      sign_in   = sign_ff;
      idx_in    = idx_ff;
      bcd_in    = bcd_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      if (loaded_ff) begin
         strobe_in = 1'b1;
         if (sign_ff) begin
            char_in = sbda_pkg::CH_MINUS;
            last_in = 1'b0;
            sign_in = 1'b0;
         end else begin
            char_in = sbda_pkg::CH_ZERO + {2'b00, digit};
            last_in = (idx_ff == '0);
            idx_in  = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               loaded_in = 1'b0;
            end
         end
      end
      if (pop) begin
         loaded_in = 1'b1;
         sign_in   = head_data.neg;
         idx_in    = msd;
         bcd_in    = head_data.bcd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         sign_ff   <= 1'b0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         sign_ff   <= sign_in;
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== src/signed_binary_to_decimal_ascii_unit.sv =====
// Top level of the signed binary to decimal ASCII unit: front end, queue and
// back end. Depends on sbda_pkg, sbda_front, sbda_queue and sbda_back.
//
//   channel   ports                                  handshake
//   -------   ------------------------------------   -------------------------------
//   request   req_value[31:0] (signed)               taken when start && !busy
//   response  rsp_character[5:0], rsp_last           one cycle, marked by rsp_strobe
//
// The front end converts a word to BCD, four double-dabble bits per cycle, and may
// take the next word in the cycle it hands its result to the queue, but takes no
// new word while it still converts the last one.
// The back end sends one character per cycle, 1 to 11 per word, with no gap
// between words while the queue holds the next word.
// Each word passes conversion, the queue, back-end load and the output register.
// Reset is synchronous and clears all control state; the queue starts empty.
// The receiver cannot stall: busy rises only while the front end converts, or
// holds a result because the two-entry queue is full.
module signed_binary_to_decimal_ascii_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sbda_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_strobe,
   output logic [sbda_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                rsp_last
);

   sbda_pkg::queue_status_type queue_status;
   sbda_pkg::entry_type        push_data;
   sbda_pkg::entry_type        head_data;
   logic                       push;
   logic                       pop;

   // Classify the word and build its BCD digits.
   sbda_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   // Hold converted words so front and back end stall independently.
   sbda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   // Serialize sign and digits onto the response ports.
   sbda_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_data     (head_data),
      .queue_status  (queue_status),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // A taken word keeps the front end busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("front end idle right after taking a word");

   // A minus sign never ends a number and is always followed by a digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_character == sbda_pkg::CH_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last character");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_character == sbda_pkg::CH_MINUS)
      |=> rsp_strobe && (rsp_character != sbda_pkg::CH_MINUS))
      else $error("minus sign not followed by a digit");

   // Never write into a full queue unless the head is popped in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full || pop)
      else $error("queue overflow");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the signed binary to decimal ASCII unit: drives signed words,
// predicts the decimal text of each and checks every character as it comes out.
// Depends on sbda_pkg and signed_binary_to_decimal_ascii_unit.

// Holds the characters still owed by the unit, oldest first.
class decimal_text_board;
   typedef struct packed {
      logic [sbda_pkg::CHAR_W-1:0] character;
      logic                        last;
   } text_char_type;

   text_char_type pending_chars[$];
   int            mismatches;
   int            char_count;

   function new();
      mismatches = 0;
      char_count = 0;
   endfunction

   task report(string msg);
      $display("mismatch at character %0d: %s", char_count, msg);
      mismatches++;
   endtask

   // Work out the decimal text of an accepted word and queue its characters.
   function void predict_text(logic [sbda_pkg::VALUE_W-1:0] raw);
      logic [sbda_pkg::VALUE_W-1:0]   mag;
      logic [3:0]                     digits [sbda_pkg::NUM_DIGITS];
      logic [sbda_pkg::CHAR_W-1:0]    text [sbda_pkg::NUM_DIGITS + 1];
      text_char_type                  entry;
      bit                             started;
      int                             n;
      mag = raw[sbda_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
      for (int k = 0; k < sbda_pkg::NUM_DIGITS; k++) begin
         digits[k] = 4'(mag % 10);
         mag = mag / 10;
      end
      n = 0;
      if (raw[sbda_pkg::VALUE_W-1]) begin
         text[n] = sbda_pkg::CH_MINUS;
         n++;
      end
      started = 0;
      for (int k = sbda_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
         if (digits[k] != 0) started = 1;
         if (started) begin
            text[n] = sbda_pkg::CH_ZERO + {2'b00, digits[k]};
            n++;
         end
      end
      if (!started) begin
         text[n] = sbda_pkg::CH_ZERO;
         n++;
      end
      for (int k = 0; k < n; k++) begin
         entry.character = text[k];
         entry.last      = (k == n - 1);
         pending_chars.push_back(entry);
      end
   endfunction

   task check_char(logic [sbda_pkg::CHAR_W-1:0] character, logic last);
      text_char_type want;
      if (pending_chars.size() == 0) begin
         report($sformatf("unexpected character %0d last %0b", character, last));
      end else begin
         want = pending_chars.pop_front();
         if (character !== want.character)
            report($sformatf("character %0d, want %0d", character, want.character));
         if (last !== want.last)
            report($sformatf("last %0b, want %0b", last, want.last));
      end
      char_count++;
   endtask

   function int pending();
      return pending_chars.size();
   endfunction
endclass

module tb_top;
   localparam int RANDOM_WORDS = 160;
   localparam int DRAIN_CYCLES = 30;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [sbda_pkg::VALUE_W-1:0] req_value;
   logic                                rsp_strobe;
   logic [sbda_pkg::CHAR_W-1:0]         rsp_character;
   logic                                rsp_last;

   decimal_text_board board;

   signed_binary_to_decimal_ascii_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Sample both channels at the rising edge. A word taken here can not have
   // text out on the same edge, so note the word before checking characters.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.predict_text(req_value);
         if (rsp_strobe) board.check_char(rsp_character, rsp_last);
      end
   end

   // Call at a falling edge. Hold start low for the gap given, then present the word and
   // hold it until the unit takes it; return at the next falling edge with
   // start still high, so a back-to-back word needs no second assignment.
   task automatic send_word(input logic [sbda_pkg::VALUE_W-1:0] v, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start and hold off until the unit has emitted all owed text.
   task automatic drain_text();
      start <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Pick a word: mostly a random digit count so short texts show up as
   // often as long ones, with a sign drawn at random; the rest full noise.
   function automatic logic [sbda_pkg::VALUE_W-1:0] random_word();
      longint unsigned span;
      longint          mag;
      int              ndig;
      if ($urandom_range(0, 3) == 0) return $urandom;
      ndig = $urandom_range(1, 10);
      span = 1;
      for (int k = 0; k < ndig; k++) span = span * 10;
      mag = {$urandom, $urandom} % span;
      if (mag > 64'd2147483647) mag = 64'd2147483647;
      if ($urandom_range(0, 1)) return sbda_pkg::VALUE_W'(-mag);
      return sbda_pkg::VALUE_W'(mag);
   endfunction

   initial begin
      logic [sbda_pkg::VALUE_W-1:0] directed [$];
      bit                           burst;
      int                           gap;
      board     = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extremes, single digits, powers of ten, the most negative value
      // and alternating bit patterns.
      directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'h7FFFFFFF,
                   32'h80000000, 32'h80000001, 32'd1000000000, 32'd999999999,
                   -32'sd1000000000, 32'd100, 32'd1000000, -32'sd7, 32'd1234567890,
                   -32'sd987654321, 32'h55555555, 32'hAAAAAAAA, 32'd100000, -32'sd9};
      foreach (directed[i]) send_word(directed[i], (i < 8) ? 0 : $urandom_range(0, 6));

      // Let the unit run dry once before the random part.
      drain_text();

      burst = 0;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // Alternate stretches of back-to-back words with randomly spaced ones.
         if (i % 25 == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 6);
         send_word(random_word(), gap);
         if (i == RANDOM_WORDS / 2) drain_text();
      end

      drain_text();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Generous bound: even with every word at eleven characters plus the longest gap,
   // the whole run ends long before this timeout.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
